/* design/ret_pkg.sv */
// Shared types and constants for the extrapolation tableau block.
package ret_pkg;

  localparam int MaxStages = 8;
  localparam int IdxW = $clog2(MaxStages);
  localparam int CntW = IdxW + 1;
  localparam int ValW = 48;
  localparam int FacW = 61;

  localparam int RegStepCount   = 0;
  localparam int RegStepDivisor = 1;
  localparam int RegMethodOrder = 2;

  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAC,
    ST_RDA,
    ST_RDB,
    ST_CAP,
    ST_DIV,
    ST_WR
  } state_t;

  // Divider request and reply
  typedef struct packed {
    logic              start;
    logic signed [49:0] num;
    logic [FacW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [49:0] quo;
    logic signed [FacW:0] rem;
  } div_rsp_t;

endpackage

/* design/ret_div.sv */
// Restoring serial divider, signed numerator, unsigned denominator, one bit a cycle.
module ret_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ret_pkg::div_req_t req,
  output ret_pkg::div_rsp_t rsp
);
  import ret_pkg::*;

  logic [49:0]     mag_r, mag_nxt;
  logic [FacW:0]   rem_r, rem_nxt;
  logic [FacW-1:0] den_r;
  logic            neg_r;
  logic [5:0]      cnt_r;
  logic            busy_r, done_r;
  logic [FacW:0]   trial;

  assign trial   = {rem_r[FacW-1:0], mag_r[49]} - {1'b0, den_r};
  assign rem_nxt = trial[FacW] ? {rem_r[FacW-1:0], mag_r[49]} : trial;
  assign mag_nxt = {mag_r[48:0], ~trial[FacW]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd50;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.num[49];
      mag_r <= req.num[49] ? 50'(-req.num) : 50'(req.num);
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Truncating result: quotient and remainder take the numerator's sign
  always_comb begin
    rsp.done = done_r;
    rsp.quo  = neg_r ? -$signed(mag_r) : $signed(mag_r);
    rsp.rem  = neg_r ? -$signed(rem_r) : $signed(rem_r);
  end

endmodule

/* design/ret_mem.sv */
// Tableau store: synchronous RAM, one write port, one registered read port.
module ret_mem (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ret_pkg::IdxW-1:0] waddr,
  input  ret_pkg::val_t           wdata,
  input  logic [ret_pkg::IdxW-1:0] raddr,
  output ret_pkg::val_t           rdata
);
  import ret_pkg::*;

  val_t mem [MaxStages];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* design/richardson_extrapolation_tableau.sv */
// Top level of the Richardson extrapolation tableau.
// Usage: write step_count, step_divisor and method_order on the cfg_ port
// (index 0, 1, 2) only while busy is low and nothing is in flight. Each word
// on in_ is one stage value of the current component, accepted at a rising
// edge with start high and busy low. Stages go into an 8-entry tableau RAM
// with a registered read port. A stage other than the last is written as it
// is accepted; busy stays low. Pass through (count 0 or 1) puts the result on
// out_ in the cycle after the accepting edge. The last stage of a count-n
// component holds busy high while, for each column k = 1 .. n-1, the factor
// divisor^(order*k), capped at 2^60, is formed by repeated multiplication, and
// then each entry i = n-1 .. k is updated: two reads, a capture, a division by
// the factor minus 1 in the shared 50-step serial divider and one write. A
// factor of 0 or 1 skips the divider, which sets the pace. The result is on
// out_ in the first cycle with busy low again. out_valid marks each result
// for one cycle; the receiver cannot stall. Reset clears the stage index and
// the registers (count 1, divisor 2, order 1); the tableau RAM is not
// cleared, entries are written before read.
module richardson_extrapolation_tableau (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [47:0]   in_stage_value,
  input  logic                 in_final_component,
  output logic                 out_valid,
  output logic signed [47:0]   out_extrapolated,
  output logic                 out_final_out,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [3:0]           cfg_data
);
  import ret_pkg::*;

  localparam logic [FacW-1:0] FacCap = FacW'(1) << 60;

  state_t state_r, state_nxt;
  logic [3:0] count_r;
  logic [2:0] divisor_r, order_r;
  logic [IdxW-1:0] idx_r;
  logic [CntW-1:0] steps;
  logic [CntW-1:0] k_r, i_r;
  logic [5:0] e_r;
  logic [FacW-1:0] f_r;
  logic fin_r;
  val_t a_r, res_r, sat_w;
  logic out_valid_r;
  logic [IdxW-1:0] pos;
  div_req_t dreq;
  div_rsp_t drsp;
  logic mwe;
  logic [IdxW-1:0] mwa, mra;
  val_t mwd, mrd;
  logic signed [50:0] s_w;
  logic [FacW+3:0] prod;

  assign steps = (count_r > 4'(MaxStages)) ? CntW'(MaxStages) : CntW'(count_r);
  assign pos = (CntW'(idx_r) > steps - CntW'(1)) ? IdxW'(steps - CntW'(1)) : idx_r;
  assign busy = (state_r != ST_IDLE);
  assign prod = (FacW+4)'(f_r) * (FacW+4)'(divisor_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd1; divisor_r <= 3'd2; order_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        2'(RegStepCount):   count_r   <= cfg_data;
        2'(RegStepDivisor): divisor_r <= cfg_data[2:0];
        2'(RegMethodOrder): order_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Combine: s = a + trunc(d/m), adjusted by the remainder sign, saturated
  always_comb begin
    s_w = 51'(a_r) + 51'($signed(drsp.quo));
    if (s_w > 51'sd0 && drsp.rem[FacW]) s_w = s_w - 51'sd1;
    else if (s_w < 51'sd0 && !drsp.rem[FacW] && drsp.rem != '0) s_w = s_w + 51'sd1;
    if (s_w > 51'sh7FFFFFFFFFFF) sat_w = 48'sh7FFFFFFFFFFF;
    else if (s_w < -51'sh800000000000) sat_w = 48'sh800000000000;
    else sat_w = s_w[47:0];
  end

  // Next state, RAM ports and divider request
  always_comb begin
    state_nxt = state_r;
    mwe = 1'b0; mwa = pos; mwd = in_stage_value;
    mra = IdxW'(i_r);
    dreq.start = 1'b0;
    dreq.num = 50'(a_r) - 50'(mrd);
    dreq.den = f_r - FacW'(1);
    unique case (state_r)
      ST_IDLE: if (start && count_r > 4'd1) begin
        mwe = 1'b1;
        if (CntW'(pos) == steps - CntW'(1)) state_nxt = ST_FAC;
      end
      ST_FAC: if (e_r == 6'd0) state_nxt = ST_RDA;
      ST_RDA: state_nxt = ST_RDB;
      ST_RDB: begin
        mra = IdxW'(i_r - CntW'(1));
        state_nxt = ST_CAP;
      end
      // t[i] in a_r, t[i-1] on the read port
      ST_CAP: begin
        if (f_r > FacW'(1)) begin
          dreq.start = 1'b1;
          state_nxt = ST_DIV;
        end else state_nxt = ST_WR;
      end
      ST_DIV: if (drsp.done) state_nxt = ST_WR;
      ST_WR: begin
        mwe = 1'b1; mwa = IdxW'(i_r); mwd = res_r;
        if (i_r == k_r) begin
          if (k_r == steps - CntW'(1)) state_nxt = ST_IDLE;
          else state_nxt = ST_FAC;
        end else state_nxt = ST_RDA;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Sequencer control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0; out_valid_r <= 1'b0;
      k_r <= '0; i_r <= '0; e_r <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (start) begin
          fin_r <= in_final_component;
          if (count_r <= 4'd1) begin
            idx_r <= '0; out_valid_r <= 1'b1; res_r <= in_stage_value;
          end else if (CntW'(pos) == steps - CntW'(1)) begin
            idx_r <= '0; k_r <= CntW'(1); i_r <= steps - CntW'(1);
            f_r <= FacW'(1); e_r <= 6'(order_r);
          end else idx_r <= pos + IdxW'(1);
        end
        ST_FAC: if (e_r != 6'd0) begin
          e_r <= e_r - 6'd1;
          if (divisor_r == 3'd0) f_r <= '0;
          else if (prod > (FacW+4)'(FacCap)) f_r <= FacCap;
          else f_r <= FacW'(prod);
        end
        ST_RDB: a_r <= mrd;
        ST_CAP: begin
          if (f_r == FacW'(1)) res_r <= a_r;
          else if (f_r == '0) res_r <= mrd;
        end
        ST_DIV: if (drsp.done) res_r <= sat_w;
        // Last write of the sweep is t[n-1]; it stays in res_r for the output
        ST_WR: begin
          if (i_r == k_r) begin
            if (k_r == steps - CntW'(1)) out_valid_r <= 1'b1;
            else begin
              k_r <= k_r + CntW'(1); i_r <= steps - CntW'(1);
              f_r <= FacW'(1); e_r <= 6'(order_r) * 6'(k_r + CntW'(1));
            end
          end else i_r <= i_r - CntW'(1);
        end
        default: ;
      endcase
    end
  end

  ret_mem u_mem (
    .clk(clk), .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd)
  );

  ret_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign out_valid = out_valid_r;
  assign out_extrapolated = res_r;
  assign out_final_out = fin_r;

`ifndef SYNTH
  // Results only appear while the sequencer is idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  // Sweep indices stay inside the tableau
  a_sweep_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |->
      (k_r >= CntW'(1) && k_r < steps && i_r >= k_r && i_r < steps))
    else $error("sweep index out of range");

  // Divider finishes only while it is awaited
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside ST_DIV");

  // Factor in range whenever the divider runs
  a_div_fac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (f_r > FacW'(1) && f_r <= FacCap))
    else $error("factor out of range during division");
`endif

endmodule
